### src/daq_word_energy_extractor_defines.svh
// Assertion macros shared by the energy extractor.
`ifndef DAQ_WORD_ENERGY_EXTRACTOR_DEFINES_SVH
`define DAQ_WORD_ENERGY_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWEE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DWEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dwee_pkg.sv
package dwee_pkg;

    localparam int NUM_SLOTS   = 7;
    localparam int SLOT_W      = 3;
    localparam int CHAN_W      = 6;
    localparam int VALUE_W     = 12;
    localparam int ENERGY_W    = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;

    // Command queue between the front and the back.
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // Calibration: energy = trunc((value - 779) * 1000 / 1293).
    // The magnitude is formed as floor(|d| * RECIP >> RECIP_SHIFT), where RECIP is
    // ceil(1000 * 2^24 / 1293). The rounding error stays below one step of 1/1293
    // for every |d| up to 3316, so the floor is exact.
    localparam logic [VALUE_W-1:0] VALUE_OFFSET = 12'd779;
    localparam int                 RECIP_W      = 24;
    localparam int                 RECIP_SHIFT  = 24;
    localparam logic [RECIP_W-1:0] RECIP        = 24'd12975419;
    localparam int                 PROD_W       = VALUE_W + RECIP_W;

    // Classification masks.
    localparam logic [31:0] MASK_ADC    = 32'h0068_0000;
    localparam logic [31:0] PAT_HG_ADC  = 32'h0000_0000;
    localparam logic [31:0] PAT_LG_ADC  = 32'h0008_0000;
    localparam logic [31:0] MASK_TDC    = 32'h0060_1000;
    localparam logic [31:0] PAT_TDC_LE  = 32'h0020_1000;
    localparam logic [31:0] PAT_TDC_TE  = 32'h0020_0000;
    localparam logic [31:0] MASK_SCALER = 32'h0060_0000;
    localparam logic [31:0] PAT_SCALER  = 32'h0040_0000;

    typedef logic [CHAN_W-1:0]          chan_t;
    typedef logic signed [ENERGY_W-1:0] energy_t;

    typedef enum logic [2:0] {
        KIND_HG_ADC = 3'd0,
        KIND_LG_ADC = 3'd1,
        KIND_TDC_LE = 3'd2,
        KIND_TDC_TE = 3'd3,
        KIND_SCALER = 3'd4,
        KIND_NONE   = 3'd7
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_KIND = 3'd0,
        REG_SLOT1       = 3'd1,
        REG_SLOT2       = 3'd2,
        REG_SLOT3       = 3'd3,
        REG_SLOT4       = 3'd4,
        REG_SLOT5       = 3'd5,
        REG_SLOT6       = 3'd6,
        REG_SLOT7       = 3'd7
    } cfg_reg_t;

    localparam logic [2:0] TARGET_KIND_RESET = KIND_LG_ADC;
    localparam chan_t SLOT_CHAN_RESET [NUM_SLOTS] =
        '{6'd43, 6'd33, 6'd34, 6'd38, 6'd40, 6'd41, 6'd43};

    // One queued command: an optional slot update and an optional event end.
    typedef struct packed {
        logic               update;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               emit;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic done;
        logic emit;
    } back_status_t;

    // Mask tests in priority order.
    function automatic kind_t classify(input logic [31:0] d);
        kind_t k;
        if ((d & MASK_ADC) == PAT_HG_ADC)
            k = KIND_HG_ADC;
        else if ((d & MASK_ADC) == PAT_LG_ADC)
            k = KIND_LG_ADC;
        else if ((d & MASK_TDC) == PAT_TDC_LE)
            k = KIND_TDC_LE;
        else if ((d & MASK_TDC) == PAT_TDC_TE)
            k = KIND_TDC_TE;
        else if ((d & MASK_SCALER) == PAT_SCALER)
            k = KIND_SCALER;
        else
            k = KIND_NONE;
        return k;
    endfunction

endpackage

### src/dwee_front.sv
module dwee_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [31:0]                   word,
    input  logic                          cfg_we,
    input  logic [dwee_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwee_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          q_push,
    output dwee_pkg::cmd_t                q_wdata
);
    import dwee_pkg::*;

    logic [2:0]         target_kind_reg;
    chan_t              slot_chan_reg [NUM_SLOTS];
    logic [VALUE_W-1:0] words_left_reg;
    logic [VALUE_W-1:0] words_left_next;

    logic               accept;
    logic               is_header;
    kind_t              kind;
    chan_t              chan;
    logic               kind_hit;
    logic               slot_found;
    logic [SLOT_W-1:0]  slot_sel;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_kind_reg <= TARGET_KIND_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_chan_reg[i] <= SLOT_CHAN_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TARGET_KIND)
                target_kind_reg <= cfg_data[2:0];
            else
                slot_chan_reg[cfg_index - CFG_IDX_W'(1)] <= cfg_data;
        end
    end

    assign accept    = in_valid && in_ready;
    assign is_header = (words_left_reg == '0);
    assign kind      = classify(word);
    assign chan      = word[18:13];
    assign kind_hit  = (kind != KIND_NONE) && (kind == kind_t'(target_kind_reg));

    // First slot whose channel matches wins.
    always_comb
    begin
        slot_found = 1'b0;
        slot_sel   = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!slot_found && (slot_chan_reg[i] == chan))
            begin
                slot_found = 1'b1;
                slot_sel   = SLOT_W'(i);
            end
        end
    end

    // Header or data word: build the command and the next count.
    always_comb
    begin
        q_wdata.update = 1'b0;
        q_wdata.slot   = slot_sel;
        q_wdata.value  = word[VALUE_W-1:0];
        q_wdata.emit   = 1'b0;
        words_left_next = words_left_reg;
        if (is_header)
        begin
            words_left_next = word[VALUE_W-1:0];
            q_wdata.emit    = (word[VALUE_W-1:0] == '0);
        end
        else
        begin
            words_left_next = words_left_reg - VALUE_W'(1);
            q_wdata.update  = kind_hit && slot_found;
            q_wdata.emit    = (words_left_reg == VALUE_W'(1));
        end
    end

    assign q_push = accept && (q_wdata.update || q_wdata.emit);

    // Event word counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            words_left_reg <= '0;
        else if (accept)
            words_left_reg <= words_left_next;
    end

endmodule

### src/dwee_queue.sv
module dwee_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dwee_pkg::cmd_t       wdata,
    input  logic                 pop,
    output dwee_pkg::cmd_t       rdata,
    output dwee_pkg::q_status_t  status
);
    import dwee_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

endmodule

### src/dwee_back.sv
module dwee_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dwee_pkg::cmd_t          q_rdata,
    input  dwee_pkg::q_status_t     q_status,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output dwee_pkg::energy_t       out_energy [dwee_pkg::NUM_SLOTS],
    output dwee_pkg::back_status_t  status
);
    import dwee_pkg::*;

    // Calibration stage.
    logic               s1_valid_reg;
    logic               s1_update_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic               s1_emit_reg;
    logic               s1_neg_reg;
    logic [PROD_W-1:0]  s1_prod_reg;

    logic signed [VALUE_W:0] diff;
    logic [VALUE_W-1:0]      diff_mag;
    logic [VALUE_W-1:0]      quot;
    energy_t                 energy;

    energy_t held_reg  [NUM_SLOTS];
    energy_t held_next [NUM_SLOTS];
    energy_t out_energy_reg [NUM_SLOTS];
    logic    out_valid_reg;

    logic    s1_done;
    logic    s1_free;

    // Offset removal and magnitude of the queue head.
    assign diff     = $signed({1'b0, q_rdata.value}) - $signed({1'b0, VALUE_OFFSET});
    assign diff_mag = diff[VALUE_W] ? VALUE_W'(-diff) : diff[VALUE_W-1:0];

    // The stage completes unless it ends an event while the output is still held.
    assign s1_done = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign s1_free = !s1_valid_reg || s1_done;
    assign q_pop   = s1_free && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= !q_status.empty;
    end

    // Constant multiply by the scaled reciprocal.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_update_reg <= q_rdata.update;
            s1_slot_reg   <= q_rdata.slot;
            s1_emit_reg   <= q_rdata.emit;
            s1_neg_reg    <= diff[VALUE_W];
            s1_prod_reg   <= PROD_W'(diff_mag) * PROD_W'(RECIP);
        end
    end

    // Truncated quotient with the sign put back.
    assign quot   = s1_prod_reg[RECIP_SHIFT +: VALUE_W];
    assign energy = s1_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            held_next[i] = held_reg[i];
        end
        if (s1_done && s1_update_reg)
            held_next[s1_slot_reg] = energy;
    end

    // Held energies persist across events.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    // Output register, loaded at the end of each event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_done && s1_emit_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_done && s1_emit_reg)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                out_energy_reg[i] <= held_next[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status.done = s1_done;
    assign status.emit = s1_emit_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            out_energy[i] = out_energy_reg[i];
        end
    end

endmodule

### src/daq_word_energy_extractor.sv
// Readout word energy extractor. Takes one 32-bit readout word per clock on the
// input channel while the queue has room: a header (low 12 bits give the number
// of data words) followed by that many data words. Data words of the configured
// kind update the energy of the first slot whose channel matches, with energy =
// trunc((value - 779) / 1.293). At the end of every event (the last data word,
// or a header with a zero count) one transfer on the output channel delivers all
// seven held energies; they are not cleared between events. Sustained rate is
// one word per cycle unless the queue is full; the front classifies a word in
// the cycle it is accepted, a four-entry command queue decouples it from the
// back, and the back registers the reciprocal multiply, then updates the held
// energies and loads the output register. A stalled output backs up the queue
// only when an event end must wait; the input then stalls once four commands
// are queued. Configuration writes take effect on the next cycle.
`include "daq_word_energy_extractor_defines.svh"

module daq_word_energy_extractor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [31:0]                     word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [12:0]              energy_one,
    output logic signed [12:0]              energy_two,
    output logic signed [12:0]              energy_three,
    output logic signed [12:0]              energy_four,
    output logic signed [12:0]              energy_five,
    output logic signed [12:0]              energy_six,
    output logic signed [12:0]              energy_seven,
    input  logic                            cfg_we,
    input  logic [dwee_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwee_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dwee_pkg::*;

    logic         q_push;
    logic         q_pop;
    cmd_t         q_wdata;
    cmd_t         q_rdata;
    q_status_t    q_stat;
    back_status_t back_stat;
    energy_t      energy [NUM_SLOTS];

    // Input transfers proceed while the queue has room.
    assign in_ready = !q_stat.full;

    dwee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .word      (word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    dwee_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_stat)
    );

    dwee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rdata    (q_rdata),
        .q_status   (q_stat),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_energy (energy),
        .status     (back_stat)
    );

    assign energy_one   = energy[0];
    assign energy_two   = energy[1];
    assign energy_three = energy[2];
    assign energy_four  = energy[3];
    assign energy_five  = energy[4];
    assign energy_six   = energy[5];
    assign energy_seven = energy[6];

    // Queue never overflows or underflows; a completed event end shows up.
    `DWEE_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, q_push, !q_stat.full, "push into full queue")
    `DWEE_ASSERT_SAME(a_queue_no_underflow, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `DWEE_ASSERT_NEXT(a_emit_presents, clk, rst_n, back_stat.done && back_stat.emit, out_valid, "event end lost")

endmodule

### tb/sv/slot_energy_checker.sv
`timescale 1ns / 100ps

// Watches the word and energy channels and the register port, keeps its own copy of the
// event state and the held slot energies, and compares every energy transfer with the
// oldest energy set that it has worked out.
module slot_energy_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [31:0]                     word,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  dwee_pkg::energy_t               energy_one,
    input  dwee_pkg::energy_t               energy_two,
    input  dwee_pkg::energy_t               energy_three,
    input  dwee_pkg::energy_t               energy_four,
    input  dwee_pkg::energy_t               energy_five,
    input  dwee_pkg::energy_t               energy_six,
    input  dwee_pkg::energy_t               energy_seven,
    input  logic                            cfg_we,
    input  logic [dwee_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwee_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatch_count,
    output int                              pending
);
    import dwee_pkg::*;

    localparam int GAIN_NUM    = 1000;
    localparam int GAIN_DEN    = 1293;
    localparam int CHAN_LSB    = 13;
    localparam int MAX_REPORTS = 10;

    typedef energy_t [NUM_SLOTS-1:0] energy_set_t;

    logic [2:0]         accepted_kind;
    chan_t              slot_chan [NUM_SLOTS];
    logic [VALUE_W-1:0] words_left;
    energy_set_t        held_energy;
    energy_set_t        due_energies [$];

    // Bits 22 and 21 split the word space; bit 19 picks the adc gain and bit 12 the tdc edge.
    function automatic kind_t word_kind(input logic [31:0] w);
        case (w[22:21])
            2'b00:   return w[19] ? KIND_LG_ADC : KIND_HG_ADC;
            2'b01:   return w[12] ? KIND_TDC_LE : KIND_TDC_TE;
            2'b10:   return KIND_SCALER;
            default: return KIND_NONE;
        endcase
    endfunction

    // Calibrated energy, with the quotient truncated toward zero.
    function automatic energy_t calibrated_energy(input logic [VALUE_W-1:0] v);
        int offset_value;
        offset_value = int'(v) - int'(VALUE_OFFSET);
        return energy_t'((offset_value * GAIN_NUM) / GAIN_DEN);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        energy_set_t seen;
        energy_set_t want;
        kind_t       kind;
        chan_t       chan;
        logic        hit;
        if (!rst_n)
        begin
            accepted_kind = TARGET_KIND_RESET;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                slot_chan[s] = SLOT_CHAN_RESET[s];
            end
            words_left     = '0;
            held_energy    = '0;
            due_energies.delete();
            pending        = 0;
            mismatch_count = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                if (cfg_reg_t'(cfg_index) == REG_TARGET_KIND)
                    accepted_kind = cfg_data[2:0];
                else
                    slot_chan[cfg_index - REG_SLOT1] = cfg_data;
            end

            // Energy transfer: compare with the oldest energy set due.
            if (out_valid && out_ready)
            begin
                seen = {energy_seven, energy_six, energy_five, energy_four,
                        energy_three, energy_two, energy_one};
                if (due_energies.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: energy transfer with no event end pending", $time);
                    mismatch_count++;
                end
                else
                begin
                    want = due_energies.pop_front();
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if (seen[s] !== want[s])
                        begin
                            if (mismatch_count < MAX_REPORTS)
                                $display("%0t: slot %0d energy expected %0d, got %0d",
                                         $time, s + 1, $signed(want[s]), $signed(seen[s]));
                            mismatch_count++;
                        end
                    end
                end
            end

            // Word transfer: a header when no data words are left, data otherwise.
            if (in_valid && in_ready)
            begin
                if (words_left == 0)
                begin
                    words_left = word[VALUE_W-1:0];
                    if (words_left == 0)
                        due_energies.push_back(held_energy);
                end
                else
                begin
                    kind = word_kind(word);
                    chan = word[CHAN_LSB +: CHAN_W];
                    hit  = 1'b0;
                    if (kind != KIND_NONE && kind == accepted_kind)
                    begin
                        // The first slot on this channel takes the energy.
                        for (int s = 0; s < NUM_SLOTS; s++)
                        begin
                            if (!hit && slot_chan[s] == chan)
                            begin
                                held_energy[s] = calibrated_energy(word[VALUE_W-1:0]);
                                hit = 1'b1;
                            end
                        end
                    end
                    words_left = words_left - 1'b1;
                    if (words_left == 0)
                        due_energies.push_back(held_energy);
                end
            end
            pending = due_energies.size();
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import dwee_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int QUIET_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int IDLE_PCT        = 18;
    localparam int PHASE_ITEMS     = 120;
    localparam int NUM_PHASES      = 9;
    localparam int CHAN_LSB        = 13;
    localparam int PRESSURE_PHASE  = 3;
    localparam int CALM_PHASE      = 6;

    localparam logic [VALUE_W-1:0] VALUE_MAX    = '1;
    localparam logic [2:0]         KIND_SPARE_A = 3'd5;
    localparam logic [2:0]         KIND_SPARE_B = 3'd6;
    localparam cfg_reg_t SLOT_REG [NUM_SLOTS] =
        '{REG_SLOT1, REG_SLOT2, REG_SLOT3, REG_SLOT4, REG_SLOT5, REG_SLOT6, REG_SLOT7};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [31:0]           word;
    logic                  out_valid;
    logic                  out_ready;
    energy_t               energy_one;
    energy_t               energy_two;
    energy_t               energy_three;
    energy_t               energy_four;
    energy_t               energy_five;
    energy_t               energy_six;
    energy_t               energy_seven;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int         mismatch_count;
    int         pending;
    int         words_sent;
    int         quiet_cycles;
    bit         calm;
    bit         hold_off_req;
    logic [2:0] cur_kind;
    chan_t      cur_chan [NUM_SLOTS];

    always #5 clk = ~clk;

    daq_word_energy_extractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word         (word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .energy_one   (energy_one),
        .energy_two   (energy_two),
        .energy_three (energy_three),
        .energy_four  (energy_four),
        .energy_five  (energy_five),
        .energy_six   (energy_six),
        .energy_seven (energy_seven),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    slot_energy_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .word           (word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .energy_one     (energy_one),
        .energy_two     (energy_two),
        .energy_three   (energy_three),
        .energy_four    (energy_four),
        .energy_five    (energy_five),
        .energy_six     (energy_six),
        .energy_seven   (energy_seven),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Builds a data word of the given kind around a channel and a value;
    // the bits that no test looks at stay random.
    function automatic logic [31:0] data_word(input kind_t kind, input chan_t chan,
                                              input logic [VALUE_W-1:0] value);
        logic [31:0] w;
        w = $urandom;
        case (kind)
            KIND_HG_ADC: w = (w & ~MASK_ADC) | PAT_HG_ADC;
            KIND_LG_ADC: w = (w & ~MASK_ADC) | PAT_LG_ADC;
            KIND_TDC_LE: w = (w & ~MASK_TDC) | PAT_TDC_LE;
            KIND_TDC_TE: w = (w & ~MASK_TDC) | PAT_TDC_TE;
            KIND_SCALER: w = (w & ~MASK_SCALER) | PAT_SCALER;
            default:     w = w | MASK_SCALER;
        endcase
        w[CHAN_LSB +: CHAN_W] = chan;
        w[VALUE_W-1:0] = value;
        return w;
    endfunction

    // Mostly well-formed words aimed at the configured kind and channels, some noise.
    function automatic logic [31:0] random_data_word();
        kind_t              kind;
        chan_t              chan;
        logic [VALUE_W-1:0] value;
        int                 pick;
        if ($urandom_range(99) < 15)
            return $urandom;
        if (cur_kind <= KIND_SCALER && $urandom_range(99) < 60)
            kind = kind_t'(cur_kind);
        else
        begin
            pick = $urandom_range(0, 5);
            kind = (pick > KIND_SCALER) ? KIND_NONE : kind_t'(pick);
        end
        if ($urandom_range(99) < 75)
            chan = cur_chan[$urandom_range(0, NUM_SLOTS - 1)];
        else
            chan = chan_t'($urandom);
        case ($urandom_range(0, 15))
            0:       value = '0;
            1:       value = VALUE_MAX;
            2:       value = VALUE_OFFSET - 1'b1;
            3:       value = VALUE_OFFSET;
            4:       value = VALUE_OFFSET + 1'b1;
            default: value = VALUE_W'($urandom);
        endcase
        return data_word(kind, chan, value);
    endfunction

    // Offers one word and holds it until the transfer; returns at the next falling edge.
    task automatic send_word(input logic [31:0] w);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        word     <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    // One event: a header with random upper bits and then its data words.
    task automatic send_event(input int count);
        logic [31:0] header;
        header = $urandom;
        header[VALUE_W-1:0] = VALUE_W'(count);
        send_word(header);
        for (int i = 0; i < count; i++)
        begin
            send_word(random_data_word());
        end
    endtask

    function automatic int event_size();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 10);
        else if (r < 95)
            return $urandom_range(11, 40);
        else
            return $urandom_range(41, 120);
    endfunction

    // Waits until every event end has been delivered and the block has gone quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Writes all registers; called at a falling edge while the block is idle.
    task automatic apply_config(input logic [2:0] kind, input chan_t chans [NUM_SLOTS]);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TARGET_KIND;
        cfg_data  <= CFG_DATA_W'(kind);
        @(negedge clk);
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            cfg_index <= SLOT_REG[s];
            cfg_data  <= chans[s];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_kind = kind;
        cur_chan = chans;
    endtask

    // Receiver: random stalls, one long hold-off on request, none in the calm phase.
    initial
    begin
        bit held_once;
        held_once = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held_once)
            begin
                held_once = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [2:0] kind;
        chan_t      chans [NUM_SLOTS];
        int         phase_start;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        word         = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TARGET_KIND;
        cfg_data     = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        words_sent   = 0;
        quiet_cycles = 0;
        cur_kind     = TARGET_KIND_RESET;
        cur_chan     = SLOT_CHAN_RESET;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty events: all header bits set above the count, and an all-zero header.
        send_word(32'hFFFF_F000);
        send_word(32'h0000_0000);

        // Value extremes under the reset settings; slot one beats slot seven on a
        // shared channel, and words of other kinds or unknown channels change nothing.
        send_word(32'h0000_0008);
        send_word(data_word(KIND_LG_ADC, cur_chan[0], VALUE_MAX));
        send_word(data_word(KIND_LG_ADC, cur_chan[1], '0));
        send_word(data_word(KIND_LG_ADC, cur_chan[2], VALUE_OFFSET));
        send_word(data_word(KIND_LG_ADC, cur_chan[3], VALUE_OFFSET - 1'b1));
        send_word(data_word(KIND_HG_ADC, cur_chan[4], 12'd100));
        send_word(data_word(KIND_LG_ADC, 6'd50, 12'd1000));
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);

        // The tdc and scaler kinds on one channel, then small and exact energies.
        send_word(32'hABCD_E005);
        send_word(data_word(KIND_TDC_LE, cur_chan[5], 12'd500));
        send_word(data_word(KIND_TDC_TE, cur_chan[5], 12'd600));
        send_word(data_word(KIND_SCALER, cur_chan[5], 12'd700));
        send_word(data_word(KIND_LG_ADC, cur_chan[5], VALUE_OFFSET + 1'b1));
        send_word(data_word(KIND_LG_ADC, cur_chan[4], 12'd2072));
        wait_idle();

        // Random phases; every phase after the first writes its own register settings.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (s > 0 && $urandom_range(99) < 25)
                    chans[s] = chans[$urandom_range(0, s - 1)];
                else
                    chans[s] = chan_t'($urandom);
            end
            case (p)
                1:
                begin
                    kind  = KIND_HG_ADC;
                    chans = '{6'd0, 6'd63, 6'd1, 6'd62, 6'd32, 6'd31, 6'd0};
                end
                2:
                begin
                    kind  = KIND_SCALER;
                    chans = '{default: 6'd63};
                end
                3:       kind = KIND_TDC_LE;
                4:       kind = KIND_TDC_TE;
                5:       kind = KIND_NONE;
                7:       kind = KIND_SPARE_A;
                8:       kind = KIND_SPARE_B;
                default: kind = 3'($urandom_range(KIND_HG_ADC, KIND_SCALER));
            endcase
            if (p > 0)
                apply_config(kind, chans);

            calm = (p == CALM_PHASE);
            if (p == PRESSURE_PHASE)
                hold_off_req = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_ITEMS)
            begin
                if (p == PRESSURE_PHASE)
                    send_event($urandom_range(0, 3));
                else
                    send_event(event_size());
            end
            wait_idle();
        end

        if (mismatch_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/dwee_pkg.sv
src/dwee_front.sv
src/dwee_queue.sv
src/dwee_back.sv
src/daq_word_energy_extractor.sv
tb/sv/slot_energy_checker.sv
tb/sv/tb.sv
